// ===== hw/rtl/tfp_pkg.sv =====
// Shared types, constants and helpers for the touch report frame parser.
package tfp_pkg;

  localparam int unsigned MAX_TOUCHES = 5;
  localparam int unsigned FRAME_BYTES = 28;
  localparam int unsigned REC_BYTES   = 5;
  localparam int unsigned POS_W       = 5;
  localparam int unsigned SLOT_W      = 3;
  localparam int unsigned CNT_W       = 3;

  localparam logic [POS_W-1:0] LAST_POS   = POS_W'(FRAME_BYTES - 1);
  localparam logic [POS_W-1:0] FIRST_REC  = POS_W'(2);
  localparam logic [7:0]       HDR_MASK   = 8'hc0;
  localparam logic [7:0]       HDR_TAG    = 8'h80;
  localparam logic [4:0]       FINGER_MSK = 5'h1f;
  localparam logic [4:0]       USED_MASK  = FINGER_MSK & 5'((1 << MAX_TOUCHES) - 1);

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_BAD_HDR = 2'd1,
    STATUS_BAD_SUM = 2'd2
  } status_e;

  typedef logic [31:0] rec_t;

  typedef struct packed {
    status_e                    status;
    logic [MAX_TOUCHES-1:0]     mask;
    rec_t [MAX_TOUCHES-1:0]     recs;
  } verdict_t;

  function automatic logic [CNT_W-1:0] count_ones5(input logic [4:0] m);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < 5; i++) begin
      n = n + CNT_W'(m[i]);
    end
    return n;
  endfunction

endpackage

// ===== hw/rtl/tfp_parse.sv =====
// Byte-wise frame parser: header, record capture, checksum and verdict.
module tfp_parse (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               beat_i,
  input  logic [7:0]         data_byte_i,
  input  logic               frame_start_i,
  output logic               at_last_o,
  output logic               load_o,
  output tfp_pkg::verdict_t  verdict_o
);
  import tfp_pkg::*;

  logic [POS_W-1:0] bp_q, bp_d;
  logic [POS_W-1:0] cs_pos_q, cs_pos_d;
  logic [4:0]       mask_q, mask_d;
  logic             hdr_q, hdr_d;
  logic [7:0]       sum_q, sum_d;
  logic             match_q, match_d;
  logic [CNT_W-1:0] rk_q, rk_d;
  logic [2:0]       rj_q, rj_d;
  rec_t [MAX_TOUCHES-1:0] rec_q, rec_d;

  logic             in_frame;
  logic [POS_W-1:0] pos;
  logic             in_rec;
  logic             is_final;

  assign pos      = frame_start_i ? '0 : bp_q;
  assign in_frame = beat_i && (frame_start_i || (bp_q != '0));
  assign in_rec   = (pos >= FIRST_REC) && (pos < cs_pos_q);
  assign is_final = in_frame && (pos == LAST_POS);

  always_comb begin
    bp_d     = bp_q;
    cs_pos_d = cs_pos_q;
    mask_d   = mask_q;
    hdr_d    = hdr_q;
    sum_d    = sum_q;
    match_d  = match_q;
    rk_d     = rk_q;
    rj_d     = rj_q;
    rec_d    = rec_q;
    if (in_frame) begin
      if (pos == '0) begin
        hdr_d    = (data_byte_i & HDR_MASK) == HDR_TAG;
        mask_d   = data_byte_i[4:0] & FINGER_MSK;
        cs_pos_d = POS_W'(FIRST_REC + POS_W'(REC_BYTES) *
                   POS_W'(count_ones5(data_byte_i[4:0] & USED_MASK)));
        sum_d    = '0;
        match_d  = 1'b0;
        rk_d     = '0;
        rj_d     = '0;
      end else if (in_rec) begin
        sum_d = sum_q + data_byte_i;
        // The fifth byte of each record only feeds the checksum.
        if (rk_q < CNT_W'(MAX_TOUCHES)) begin
          unique case (rj_q)
            3'd0:    rec_d[rk_q[SLOT_W-1:0]][31:24] = data_byte_i;
            3'd1:    rec_d[rk_q[SLOT_W-1:0]][23:16] = data_byte_i;
            3'd2:    rec_d[rk_q[SLOT_W-1:0]][15:8]  = data_byte_i;
            3'd3:    rec_d[rk_q[SLOT_W-1:0]][7:0]   = data_byte_i;
            default: ;
          endcase
        end
        if (rj_q == 3'(REC_BYTES - 1)) begin
          rj_d = '0;
          rk_d = rk_q + 1'b1;
        end else begin
          rj_d = rj_q + 1'b1;
        end
      end else if (pos == cs_pos_q) begin
        match_d = data_byte_i == sum_q;
      end
      bp_d = is_final ? '0 : pos + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bp_q     <= '0;
      cs_pos_q <= '0;
      mask_q   <= '0;
      hdr_q    <= 1'b0;
      sum_q    <= '0;
      match_q  <= 1'b0;
      rk_q     <= '0;
      rj_q     <= '0;
    end else begin
      bp_q     <= bp_d;
      cs_pos_q <= cs_pos_d;
      mask_q   <= mask_d;
      hdr_q    <= hdr_d;
      sum_q    <= sum_d;
      match_q  <= match_d;
      rk_q     <= rk_d;
      rj_q     <= rj_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign at_last_o = bp_q == LAST_POS;
  assign load_o    = is_final;

  always_comb begin
    verdict_o.mask = mask_q[MAX_TOUCHES-1:0] & USED_MASK[MAX_TOUCHES-1:0];
    verdict_o.recs = rec_q;
    priority if (!hdr_q) begin
      verdict_o.status = STATUS_BAD_HDR;
    end else if (!match_d) begin
      verdict_o.status = STATUS_BAD_SUM;
    end else begin
      verdict_o.status = STATUS_OK;
    end
  end

  // A frame can only finish from its last byte position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_o |-> (bp_q == LAST_POS && !frame_start_i))
    else $error("frame finished away from its last byte");

endmodule

// ===== hw/rtl/tfp_emit.sv =====
// Verdict holding register and per-slot result sequencer.
module tfp_emit (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  tfp_pkg::verdict_t      verdict_i,
  output logic                   busy_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [2:0]             slot_o,
  output logic                   active_o,
  output logic [15:0]            pos_x_o,
  output logic [15:0]            pos_y_o,
  output tfp_pkg::status_e       status_o,
  output logic                   last_o
);
  import tfp_pkg::*;

  logic              busy_q, busy_d;
  logic [SLOT_W-1:0] idx_q, idx_d;
  logic [SLOT_W-1:0] rp_q, rp_d;
  verdict_t          vd_q, vd_d;
  logic              act;
  logic              beat;
  rec_t              rec;

  assign act  = (vd_q.status == STATUS_OK) && vd_q.mask[idx_q];
  assign rec  = vd_q.recs[rp_q];
  assign beat = busy_q && out_ready_i;

  assign out_valid_o = busy_q;
  assign busy_o      = busy_q;
  assign slot_o      = idx_q;
  assign active_o    = act;
  assign pos_x_o     = act ? rec[31:16] : '0;
  assign pos_y_o     = act ? rec[15:0]  : '0;
  assign status_o    = vd_q.status;
  assign last_o      = (vd_q.status != STATUS_OK) || (idx_q == SLOT_W'(MAX_TOUCHES - 1));

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    rp_d   = rp_q;
    vd_d   = vd_q;
    if (load_i) begin
      busy_d = 1'b1;
      idx_d  = '0;
      rp_d   = '0;
      vd_d   = verdict_i;
    end else if (beat) begin
      if (last_o) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + 1'b1;
        // Records are packed in slot order, so step only past active slots.
        rp_d  = rp_q + SLOT_W'(act);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
      rp_q   <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
      rp_q   <= rp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    vd_q <= vd_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> (!busy_q || (out_ready_i && last_o)))
    else $error("new verdict overwrote one still being sent");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && status_o != STATUS_OK) |-> (!active_o && last_o && slot_o == '0))
    else $error("error verdict is not a single empty beat");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (idx_q < SLOT_W'(MAX_TOUCHES) && rp_q <= idx_q))
    else $error("slot or record pointer out of range");

endmodule

// ===== hw/rtl/touch_report_frame_parser_top.sv =====
// Top level of the touch report frame parser.
//
//   channel  direction  handshake                  payload
//   input    in         in_valid_i / in_ready_o    data_byte_i, frame_start_i
//   output   out        out_valid_o / out_ready_i  slot_o, active_o, pos_x_o,
//                                                  pos_y_o, status_o, last_o
//
// One byte is taken per cycle; state updates in the cycle the beat is accepted.
// The last byte of a frame loads the verdict register, and results leave from it
// starting the next cycle: five beats for a good frame, one beat for an error.
// Input stalls only when a frame's last byte is due while the previous verdict
// still has beats to send. Reset leaves no frame open and no result pending.
module touch_report_frame_parser_top (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [7:0]             data_byte_i,
  input  logic                   frame_start_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [2:0]             slot_o,
  output logic                   active_o,
  output logic [15:0]            pos_x_o,
  output logic [15:0]            pos_y_o,
  output tfp_pkg::status_e       status_o,
  output logic                   last_o
);
  import tfp_pkg::*;

  logic     in_beat;
  logic     at_last;
  logic     load;
  logic     busy;
  verdict_t verdict;

  assign in_ready_o = !(at_last && busy && !(out_ready_i && last_o));
  assign in_beat    = in_valid_i && in_ready_o;

  tfp_parse u_parse (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .beat_i        (in_beat),
    .data_byte_i   (data_byte_i),
    .frame_start_i (frame_start_i),
    .at_last_o     (at_last),
    .load_o        (load),
    .verdict_o     (verdict)
  );

  tfp_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .verdict_i   (verdict),
    .busy_o      (busy),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .slot_o      (slot_o),
    .active_o    (active_o),
    .pos_x_o     (pos_x_o),
    .pos_y_o     (pos_y_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

endmodule

// ===== verif/touch_report_frame_parser_top_tb.sv =====
// Randomized self-checking testbench for the touch report frame parser top level.
`timescale 1ns / 1ps

module touch_report_frame_parser_top_tb;
  import tfp_pkg::*;

  localparam int IdleLimit = 3000;
  localparam int LongHold  = 300;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } report_byte_t;

  typedef struct packed {
    logic [2:0]  slot;
    logic        active;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    status_e     status;
    logic        last;
  } slot_report_t;

  typedef enum int {FILL_RAND, FILL_ONES, FILL_ZEROS} fill_e;

  logic        clk_i = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [7:0]  data_byte = 8'h00;
  logic        frame_start = 1'b0;
  logic        out_ready = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [2:0]  slot;
  logic        active;
  logic [15:0] pos_x;
  logic [15:0] pos_y;
  status_e     status;
  logic        last;

  report_byte_t byte_q[$];
  slot_report_t slot_report_q[$];

  // Predictor state, mirrors what the parser keeps between bytes.
  logic [4:0]  frame_pos = '0;
  logic [4:0]  finger_bits = '0;
  logic        header_ok = 1'b0;
  logic [7:0]  record_sum = '0;
  logic        sum_ok = 1'b0;
  logic [31:0] finger_rec [MAX_TOUCHES];

  int err_cnt = 0;
  int idle_cycles = 0;
  int send_gap = 0;
  int send_burst = 0;
  int hold_left = 0;
  int ready_burst = 0;
  int beats_seen = 0;
  int roll_tx;
  int roll_rx;
  int bytes_sent = 0;

  always #5 clk_i = ~clk_i;

  touch_report_frame_parser_top u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .data_byte_i  (data_byte),
    .frame_start_i(frame_start),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .slot_o       (slot),
    .active_o     (active),
    .pos_x_o      (pos_x),
    .pos_y_o      (pos_y),
    .status_o     (status),
    .last_o       (last)
  );

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    err_cnt++;
  endtask

  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Advances the predicted parser by one accepted byte and queues the slot
  // reports that the byte releases.
  task automatic parse_byte(input logic [7:0] b, input logic start);
    int pos;
    int rec_end;
    int k;
    int j;
    int rec;
    slot_report_t r;
    if (start) begin
      pos = 0;
    end else if (frame_pos == 0) begin
      return;
    end else begin
      pos = frame_pos;
    end
    if (pos == 0) begin
      header_ok = (b & HDR_MASK) == HDR_TAG;
      finger_bits = b[4:0];
      record_sum = '0;
      sum_ok = 1'b0;
    end else begin
      rec_end = 2 + REC_BYTES * $countones(finger_bits & USED_MASK);
      if (pos >= 2 && pos < rec_end) begin
        k = (pos - 2) / REC_BYTES;
        j = (pos - 2) % REC_BYTES;
        record_sum = record_sum + b;
        // The fifth byte of each record only feeds the checksum.
        if (k < MAX_TOUCHES && j < 4) finger_rec[k][(3 - j) * 8 +: 8] = b;
      end else if (pos == rec_end) begin
        sum_ok = b == record_sum;
      end
    end
    if (pos == FRAME_BYTES - 1) begin
      frame_pos = '0;
      r = '0;
      r.last = 1'b1;
      if (!header_ok) begin
        r.status = STATUS_BAD_HDR;
        slot_report_q.push_back(r);
      end else if (!sum_ok) begin
        r.status = STATUS_BAD_SUM;
        slot_report_q.push_back(r);
      end else begin
        rec = 0;
        for (k = 0; k < MAX_TOUCHES; k++) begin
          r = '0;
          r.slot = 3'(k);
          r.active = finger_bits[k] & USED_MASK[k];
          r.status = STATUS_OK;
          r.last = k == MAX_TOUCHES - 1;
          if (r.active) begin
            r.pos_x = finger_rec[rec][31:16];
            r.pos_y = finger_rec[rec][15:0];
            rec++;
          end
          slot_report_q.push_back(r);
        end
      end
    end else begin
      frame_pos = 5'(pos + 1);
    end
  endtask

  task automatic push_byte(input logic [7:0] b, input logic start);
    report_byte_t it;
    it.data = b;
    it.start = start;
    byte_q.push_back(it);
  endtask

  // Builds one report frame and queues its first keep bytes.
  task automatic add_frame(input logic [7:0] hdr, input fill_e fill, input bit bad_sum,
                           input int keep);
    logic [7:0] fb[$];
    logic [7:0] sum;
    logic [7:0] b;
    int i;
    sum = '0;
    fb.push_back(hdr);
    fb.push_back(8'($urandom));
    for (i = 0; i < REC_BYTES * $countones(hdr[4:0] & USED_MASK); i++) begin
      case (fill)
        FILL_ONES:  b = 8'hff;
        FILL_ZEROS: b = 8'h00;
        default:    b = 8'($urandom);
      endcase
      sum = sum + b;
      fb.push_back(b);
    end
    fb.push_back(bad_sum ? sum ^ 8'($urandom_range(1, 255)) : sum);
    while (fb.size() < FRAME_BYTES) fb.push_back(8'($urandom));
    for (i = 0; i < keep; i++) push_byte(fb[i], i == 0);
    bytes_sent += keep;
  endtask

  function automatic logic [7:0] bad_header();
    logic [1:0] top;
    top = 2'($urandom_range(0, 2));
    if (top == 2'b10) top = 2'b11;
    return {top, 6'($urandom)};
  endfunction

  // Driver: offers the queued bytes and runs the predictor on every accepted beat.
  always @(posedge clk_i) begin
    if (rst_n) begin
      if (in_valid && in_ready) parse_byte(data_byte, frame_start);
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (byte_q.size() != 0) begin
          in_valid <= 1'b1;
          data_byte <= byte_q[0].data;
          frame_start <= byte_q[0].start;
          void'(byte_q.pop_front());
          roll_tx = $urandom_range(0, 99);
          if (send_burst > 0) begin
            send_burst <= send_burst - 1;
          end else if (roll_tx < 55) begin
            send_gap <= 0;
          end else if (roll_tx < 60) begin
            send_burst <= $urandom_range(30, 90);
          end else begin
            send_gap <= pick_gap();
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result beat against the oldest prediction and
  // throttles the result channel.
  always @(posedge clk_i) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (slot_report_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result slot %0d status %0d", slot, status));
        end else begin
          if (slot !== slot_report_q[0].slot)
            report_mismatch($sformatf("slot got %0d expected %0d", slot,
                                      slot_report_q[0].slot));
          if (active !== slot_report_q[0].active)
            report_mismatch($sformatf("active got %0b expected %0b", active,
                                      slot_report_q[0].active));
          if (pos_x !== slot_report_q[0].pos_x)
            report_mismatch($sformatf("pos_x got %h expected %h", pos_x,
                                      slot_report_q[0].pos_x));
          if (pos_y !== slot_report_q[0].pos_y)
            report_mismatch($sformatf("pos_y got %h expected %h", pos_y,
                                      slot_report_q[0].pos_y));
          if (status !== slot_report_q[0].status)
            report_mismatch($sformatf("status got %0d expected %0d", status,
                                      slot_report_q[0].status));
          if (last !== slot_report_q[0].last)
            report_mismatch($sformatf("last got %0b expected %0b", last,
                                      slot_report_q[0].last));
          void'(slot_report_q.pop_front());
        end
        beats_seen++;
      end
      // Two long hold-offs let the parser fill up and push back on its input.
      if (out_valid && out_ready && (beats_seen == 9 || beats_seen == 19)) begin
        hold_left <= LongHold - 1;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (ready_burst > 0) begin
        ready_burst <= ready_burst - 1;
        out_ready <= 1'b1;
      end else begin
        roll_rx = $urandom_range(0, 99);
        if (roll_rx < 65) begin
          out_ready <= 1'b1;
        end else if (roll_rx < 70) begin
          ready_burst <= $urandom_range(20, 80);
          out_ready <= 1'b1;
        end else begin
          hold_left <= pick_gap() - 1;
          out_ready <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("Simulation FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int roll;
    // Bytes with no frame open are dropped.
    push_byte(8'h00, 1'b0);
    push_byte(8'hff, 1'b0);
    // All five fingers: the checksum lands on the last frame byte.
    add_frame(8'h9f, FILL_ONES, 1'b0, FRAME_BYTES);
    add_frame(8'hbf, FILL_ZEROS, 1'b0, FRAME_BYTES);
    add_frame(8'h80, FILL_RAND, 1'b0, FRAME_BYTES);
    add_frame(8'hc0, FILL_RAND, 1'b0, FRAME_BYTES);
    add_frame(8'h95, FILL_RAND, 1'b1, FRAME_BYTES);
    // A new start drops the open frame without a result.
    add_frame(8'h83, FILL_RAND, 1'b0, 12);
    add_frame(8'h81, FILL_ONES, 1'b0, FRAME_BYTES);

    while (bytes_sent < 220) begin
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        add_frame({2'b10, 6'($urandom)}, FILL_RAND, 1'b0, FRAME_BYTES);
      end else if (roll < 78) begin
        add_frame(bad_header(), FILL_RAND, 1'b0, FRAME_BYTES);
      end else if (roll < 86) begin
        add_frame({2'b10, 6'($urandom)}, FILL_RAND, 1'b1, FRAME_BYTES);
      end else if (roll < 93) begin
        add_frame({2'b10, 6'($urandom)}, FILL_RAND, 1'b0, $urandom_range(1, FRAME_BYTES - 1));
      end else begin
        repeat ($urandom_range(1, 4)) push_byte(8'($urandom), 1'b0);
      end
    end

    repeat (12) @(posedge clk_i);
    rst_n <= 1'b1;

    while (byte_q.size() != 0 || in_valid || slot_report_q.size() != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
